FILE: src/map_pkg.sv
package map_pkg;

  localparam int COST_W    = 32;
  localparam int ACC_W     = 40;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_W     = 6;

  localparam logic [ACC_W-1:0] COST_INF = {ACC_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 1'b0,
    REG_COLS = 1'b1
  } map_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_FETCH,
    S_EMIT
  } map_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture cost, read column memory
    logic calc;   // update cell, write back, advance counters
    logic fetch;  // read decision bit of current path cell
    logic step;   // move path one column left, and one row up on a diagonal decision
  } map_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_cell;
    logic bt_done;
  } map_sts_t;

endpackage

FILE: src/map_ctrl.sv
module map_ctrl
  import map_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output map_cmd_t cmd,
  input  map_sts_t sts
);

  map_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.last_cell ? S_FETCH : S_IDLE;
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.step  = 1'b1;
          state_nxt = sts.bt_done ? S_IDLE : S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: src/map_dp.sv
module map_dp
  import map_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [COST_W-1:0]    in_cost,
  input  map_cmd_t             cmd,
  output map_sts_t             sts,
  output logic [IDX_W-1:0]     out_column_index,
  output logic [IDX_W-1:0]     out_row_index,
  output logic [ACC_W-1:0]     out_total_cost,
  output logic                 out_last_of_run
);

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;

  logic [CFG_W-1:0]  rows_r, cols_r;
  logic [RIW-1:0]    row_r, bt_row_r;
  logic [CIW-1:0]    col_r, bt_col_r;
  logic [RIW-1:0]    nr_m1;
  logic [CIW-1:0]    nc_m1;
  logic              last_row, last_col;
  logic [COST_W-1:0] cost_r;
  logic [ACC_W-1:0]  diag_r;
  logic [ACC_W-1:0]  total_r;
  logic [ACC_W-1:0]  cc_rd_r;
  logic              dec_rd_r;

  logic [ACC_W-1:0]  cc_mem [MAX_ROWS];
  logic              dec_mem [MAX_ROWS*MAX_COLS];

  logic              keep;
  logic [ACC_W-1:0]  base;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  val;
  logic              dec_we;
  logic [AW-1:0]     wr_addr, rd_addr;

  // clamp register values to the supported matrix size
  always_comb begin
    priority if (rows_r == '0)              nr_m1 = '0;
    else if (int'(rows_r) >= MAX_ROWS)      nr_m1 = RIW'(MAX_ROWS - 1);
    else                                    nr_m1 = RIW'(int'(rows_r) - 1);
    priority if (cols_r == '0)              nc_m1 = '0;
    else if (int'(cols_r) >= MAX_COLS)      nc_m1 = CIW'(MAX_COLS - 1);
    else                                    nc_m1 = CIW'(int'(cols_r) - 1);
  end

  assign last_row = (row_r == nr_m1);
  assign last_col = (col_r == nc_m1);

  // cheaper predecessor wins, tie goes to the diagonal
  always_comb begin
    keep = (cc_rd_r < diag_r);
    if (row_r == '0) begin
      base = cc_rd_r;
    end else begin
      base = keep ? cc_rd_r : diag_r;
    end
    sum = {1'b0, base} + {{(ACC_W + 1 - COST_W){1'b0}}, cost_r};
    if (col_r == '0) begin
      val = (row_r == '0) ? {{(ACC_W - COST_W){1'b0}}, cost_r} : COST_INF;
    end else if (base == COST_INF || sum >= {1'b0, COST_INF}) begin
      val = COST_INF;
    end else begin
      val = sum[ACC_W-1:0];
    end
  end

  assign dec_we  = cmd.calc && (row_r != '0) && (col_r != '0);
  assign wr_addr = AW'(int'(col_r) * MAX_ROWS) + AW'(row_r);
  assign rd_addr = AW'(int'(bt_col_r) * MAX_ROWS) + AW'(bt_row_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r   <= CFG_W'(64);
      cols_r   <= CFG_W'(64);
      row_r    <= '0;
      col_r    <= '0;
      diag_r   <= '0;
      bt_row_r <= '0;
      bt_col_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (map_reg_t'(cfg_index))
          REG_ROWS: rows_r <= cfg_wdata;
          REG_COLS: cols_r <= cfg_wdata;
          default:  ;
        endcase
        row_r <= '0;
        col_r <= '0;
      end else if (cmd.calc) begin
        if (col_r != '0) begin
          diag_r <= cc_rd_r;
        end
        if (!last_row) begin
          row_r <= row_r + 1'b1;
        end else begin
          row_r <= '0;
          col_r <= last_col ? '0 : col_r + 1'b1;
        end
        if (last_row && last_col) begin
          bt_row_r <= nr_m1;
          bt_col_r <= nc_m1;
        end
      end else if (cmd.step) begin
        if (bt_col_r != '0 && bt_row_r != '0 && dec_rd_r) begin
          bt_row_r <= bt_row_r - 1'b1;
        end
        bt_col_r <= bt_col_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cost_r <= in_cost;
    end
    if (cmd.calc && last_row && last_col) begin
      total_r <= val;
    end
  end

  // column cost memory: read on load, write back on calc
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cc_rd_r <= cc_mem[row_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      cc_mem[row_r] <= val;
    end
  end

  // decision bit memory
  always_ff @(posedge clk) begin
    if (dec_we) begin
      dec_mem[wr_addr] <= ~keep;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      dec_rd_r <= dec_mem[rd_addr];
    end
  end

  assign sts.last_cell = last_row && last_col;
  assign sts.bt_done   = (bt_col_r == '0);

  assign out_column_index = IDX_W'(bt_col_r);
  assign out_row_index    = IDX_W'(bt_row_r);
  assign out_total_cost   = total_r;
  assign out_last_of_run  = (bt_col_r == '0);

endmodule

FILE: src/monotone_alignment_path.sv
// Monotone alignment path. Feed the cost matrix one 32-bit cost per request in
// column-major order (all rows of column 0, then column 1, ...). For each cost
// the block first accepts it and reads the stored column cost of its row, then
// updates that cell and writes it back; no new cost is taken before the update
// ends. The last cost of the matrix starts the backtrack, which returns one
// result per column, last column first, reading the decision bit and then
// presenting the result, held while the output stalls; no cost is taken while
// results are pending. A write to cfg restarts the matrix at cell (0,0); write
// it only while the block is idle.
module monotone_alignment_path
  import map_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COST_W-1:0]    in_cost,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_column_index,
  output logic [IDX_W-1:0]     out_row_index,
  output logic [ACC_W-1:0]     out_total_cost,
  output logic                 out_last_of_run
);

  map_cmd_t cmd;
  map_sts_t sts;

  map_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  map_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_cost          (in_cost),
    .cmd              (cmd),
    .sts              (sts),
    .out_column_index (out_column_index),
    .out_row_index    (out_row_index),
    .out_total_cost   (out_total_cost),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

FILE: src/map_chk.sv
module map_chk
  import map_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [IDX_W-1:0]     out_column_index,
  input logic [IDX_W-1:0]     out_row_index,
  input logic [ACC_W-1:0]     out_total_cost,
  input logic                 out_last_of_run
);

  // no request is taken while a result is pending
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("in_ready high while a result is pending");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_row_index) &&
      $stable(out_column_index) && $stable(out_total_cost))
    else $error("stalled result changed");

  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> out_column_index == '0)
    else $error("end of run not on column zero");

  // backtrack keeps going until the column-zero result is taken
  a_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> !in_ready)
    else $error("backtrack ended early");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_of_run |=> in_ready && !out_valid)
    else $error("block not idle after end of run");

endmodule

bind monotone_alignment_path map_chk u_map_chk (.*);

FILE: tb/sv/monotone_alignment_path_test.sv
`timescale 1ns / 1ps

import map_pkg::*;

class path_scoreboard;
  localparam int unsigned ROWS_MAX = 64;
  localparam int unsigned COLS_MAX = 64;

  typedef struct packed {
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] row;
    logic [ACC_W-1:0] total;
    logic             last;
  } path_entry_t;

  path_entry_t      expected_path[$];
  logic [ACC_W-1:0] acc_col [ROWS_MAX];
  logic [ACC_W-1:0] diag_hold;
  bit               diag_move [COLS_MAX][ROWS_MAX];
  int unsigned      row_pos;
  int unsigned      col_pos;
  logic [CFG_W-1:0] rows_reg;
  logic [CFG_W-1:0] cols_reg;
  int               errors;
  int               printed;

  function new();
    foreach (acc_col[i]) acc_col[i] = '0;
    foreach (diag_move[j, i]) diag_move[j][i] = 1'b0;
    diag_hold = '0;
    row_pos   = 0;
    col_pos   = 0;
    rows_reg  = CFG_W'(ROWS_MAX);
    cols_reg  = CFG_W'(COLS_MAX);
    errors    = 0;
    printed   = 0;
  endfunction

  function int unsigned clamp_count(logic [CFG_W-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function int unsigned eff_rows();
    return clamp_count(rows_reg, ROWS_MAX);
  endfunction

  function int unsigned eff_cols();
    return clamp_count(cols_reg, COLS_MAX);
  endfunction

  function int unsigned cells_left();
    return eff_rows() * eff_cols() - (col_pos * eff_rows() + row_pos);
  endfunction

  function int outstanding();
    return expected_path.size();
  endfunction

  // any register write restarts the matrix, stored columns stay
  function void configure(map_reg_t idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_ROWS: rows_reg = val;
      REG_COLS: cols_reg = val;
      default: ;
    endcase
    row_pos = 0;
    col_pos = 0;
  endfunction

  function logic [ACC_W-1:0] sat_add(logic [ACC_W-1:0] acc, logic [COST_W-1:0] c);
    logic [ACC_W:0] s;
    if (acc == COST_INF) return COST_INF;
    s = {1'b0, acc} + {{(ACC_W-COST_W+1){1'b0}}, c};
    if (s >= {1'b0, COST_INF}) return COST_INF;
    return s[ACC_W-1:0];
  endfunction

  function void note_cost(logic [COST_W-1:0] c);
    int unsigned      nr;
    int unsigned      nc;
    int unsigned      i;
    int unsigned      j;
    int               r;
    logic [ACC_W-1:0] acc_val;
    logic [ACC_W-1:0] prev;
    bit               keep;
    path_entry_t      e;
    nr = eff_rows();
    nc = eff_cols();
    i  = (row_pos >= nr) ? nr - 1 : row_pos;
    j  = (col_pos >= nc) ? nc - 1 : col_pos;
    if (j == 0) begin
      acc_val = (i == 0) ? {{(ACC_W-COST_W){1'b0}}, c} : COST_INF;
    end else begin
      prev = acc_col[i];
      if (i == 0) begin
        acc_val = sat_add(prev, c);
      end else begin
        // tie goes to the diagonal
        keep = prev < diag_hold;
        acc_val = sat_add(keep ? prev : diag_hold, c);
        diag_move[j][i] = !keep;
      end
      diag_hold = prev;
    end
    acc_col[i] = acc_val;
    if (i + 1 < nr) begin
      row_pos = i + 1;
      col_pos = j;
      return;
    end
    row_pos = 0;
    if (j + 1 < nc) begin
      col_pos = j + 1;
      return;
    end
    col_pos = 0;
    // walk back from the bottom-right cell, last column first
    r = nr - 1;
    for (int k = int'(nc) - 1; k >= 0; k--) begin
      e.col   = IDX_W'(k);
      e.row   = IDX_W'(r);
      e.total = acc_val;
      e.last  = (k == 0);
      expected_path.push_back(e);
      if (k > 0 && r > 0 && diag_move[k][r]) r--;
    end
  endfunction

  task report(string msg);
    errors++;
    if (printed < 100) begin
      $display("%0t path check: %s", $time, msg);
      printed++;
    end
  endtask

  task check_path_entry(logic [IDX_W-1:0] col, logic [IDX_W-1:0] row,
                        logic [ACC_W-1:0] total, logic last);
    path_entry_t e;
    if (expected_path.size() == 0) begin
      report($sformatf("unexpected result col %0d row %0d", col, row));
      return;
    end
    e = expected_path.pop_front();
    if (col !== e.col)
      report($sformatf("column_index %0d, want %0d", col, e.col));
    if (row !== e.row)
      report($sformatf("row_index %0d, want %0d (col %0d)", row, e.row, e.col));
    if (total !== e.total)
      report($sformatf("total_cost %h, want %h (col %0d)", total, e.total, e.col));
    if (last !== e.last)
      report($sformatf("last_of_run %b, want %b (col %0d)", last, e.last, e.col));
  endtask
endclass

module monotone_alignment_path_test;
  import map_pkg::*;

  typedef enum int {
    COST_TIES,
    COST_WIDE,
    COST_MIXED,
    COST_HUGE
  } cost_mix_t;

  localparam int unsigned RANDOM_COSTS = 470;
  localparam int unsigned CALM_AFTER   = 400;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic [COST_W-1:0]    in_cost;
  logic                 out_valid;
  logic                 out_ready;
  logic [IDX_W-1:0]     out_column_index;
  logic [IDX_W-1:0]     out_row_index;
  logic [ACC_W-1:0]     out_total_cost;
  logic                 out_last_of_run;

  path_scoreboard path_sb;
  bit             calm;
  int unsigned    costs_sent;

  monotone_alignment_path i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cost          (in_cost),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_column_index (out_column_index),
    .out_row_index    (out_row_index),
    .out_total_cost   (out_total_cost),
    .out_last_of_run  (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      path_sb.check_path_entry(out_column_index, out_row_index, out_total_cost,
                               out_last_of_run);
  end

  // receiver stalls in bursts, none once the run calms down
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
        if (!calm) repeat ($urandom_range(0, 10)) @(negedge clk);
      end
    end
  end

  function automatic logic [COST_W-1:0] pick_cost(cost_mix_t mix);
    logic [COST_W-1:0] v;
    case (mix)
      COST_TIES: v = $urandom_range(0, 3);
      COST_WIDE: v = $urandom();
      COST_HUGE: v = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          2: v = $urandom_range(0, 15);
          default: v = $urandom();
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_cost(input logic [COST_W-1:0] c);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_cost  = c;
    do @(posedge clk); while (!in_ready);
    path_sb.note_cost(c);
    costs_sent++;
  endtask

  // drop the request, wait for every pending result, then let the block settle
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (path_sb.outstanding() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input map_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    path_sb.configure(idx, val);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic set_shape(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    quiesce();
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
  endtask

  task automatic feed_costs(input cost_mix_t mix, input int unsigned count);
    repeat (count) send_cost(pick_cost(mix));
  endtask

  initial begin
    int unsigned sel;
    int unsigned iter;
    cost_mix_t   mix;
    path_sb    = new();
    calm       = 1'b0;
    costs_sent = 0;
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = REG_ROWS;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_cost    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single cell, largest cost
    set_shape(1, 1);
    send_cost(32'hFFFF_FFFF);
    // zero counts clamp to one
    set_shape(0, 0);
    send_cost(32'h0);
    // single column of several rows ends at infinity
    set_shape(3, 1);
    send_cost(32'd5);
    send_cost(32'hFFFF_FFFF);
    send_cost(32'd7);
    // restart mid-matrix, then equal costs so some choices are ties
    set_shape(2, 3);
    repeat (3) send_cost(32'd1);
    quiesce();
    write_reg(REG_COLS, 3);
    repeat (6) send_cost(32'd1);
    set_shape(3, 3);
    send_cost(32'd0);
    send_cost(32'd9);
    send_cost(32'hFFFF_FFFF);
    send_cost(32'hFFFF_FFFF);
    send_cost(32'd2);
    send_cost(32'd0);
    send_cost(32'd3);
    send_cost(32'd0);
    send_cost(32'd1);

    costs_sent = 0;
    iter       = 0;
    while (costs_sent < RANDOM_COSTS) begin
      if (costs_sent >= CALM_AFTER) calm = 1'b1;
      sel = $urandom_range(0, 19);
      if (iter == 0) begin
        set_shape(127, 1);
      end else if (iter == 1) begin
        set_shape(2, 64);
      end else if (sel == 0) begin
        // keep the shape, next matrix follows back to back
      end else if (sel == 1) begin
        if ($urandom_range(0, 1) == 0)
          set_shape(CFG_W'($urandom_range(64, 127)), CFG_W'($urandom_range(1, 2)));
        else
          set_shape(CFG_W'($urandom_range(1, 2)), CFG_W'($urandom_range(64, 127)));
      end else if (sel == 2) begin
        quiesce();
        write_reg(REG_ROWS, CFG_W'($urandom_range(0, 8)));
      end else begin
        set_shape(CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)));
      end
      mix = cost_mix_t'($urandom_range(0, 3));
      if ($urandom_range(0, 11) == 0 && path_sb.cells_left() > 1) begin
        // abandon a partial matrix and restart it
        feed_costs(mix, $urandom_range(1, path_sb.cells_left() - 1));
        quiesce();
        write_reg(REG_COLS, path_sb.cols_reg);
      end
      feed_costs(mix, path_sb.cells_left());
      iter++;
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (path_sb.outstanding() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (path_sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
